>>> hdl/bst_pkg.sv
// shared types, constants and helpers for the byte stream tokenizer
// used by bst_lex_step and byte_stream_tokenizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int CountBits = 16;
  localparam int FieldBits = 16;
  localparam int KwCount   = 3;

  typedef logic [CountBits-1:0] cnt_t;
  typedef logic [FieldBits-1:0] field_t;

  // token kinds as carried on the output
  typedef enum logic [2:0] {
    KIdent   = 3'd0,
    KKeyword = 3'd1,
    KNumber  = 3'd2,
    KSymbol  = 3'd3,
    KString  = 3'd4,
    KEnd     = 3'd5,
    KError   = 3'd6
  } kind_e;

  // lexer mode, one-hot
  typedef enum logic [6:0] {
    ModeIdle    = 7'b0000001,
    ModeIdent   = 7'b0000010,
    ModeNumber  = 7'b0000100,
    ModeString  = 7'b0001000,
    ModeSlash   = 7'b0010000,
    ModeComment = 7'b0100000,
    ModeHalt    = 7'b1000000
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    cnt_t               line;
    cnt_t               col;
    cnt_t               start;
    cnt_t               len;
    logic [KwCount-1:0] kw;
  } lex_state_t;

  typedef struct packed {
    kind_e  kind;
    field_t line;
    field_t column;
    field_t length;
    logic   last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } step_t;

  // keyword lengths: set, put, tile
  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] l;
    unique case (k)
      0:       l = 3'd3;
      1:       l = 3'd3;
      default: l = 3'd4;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input int k, input logic [1:0] p);
    logic [31:0] s;
    unique case (k)
      0:       s = {"set", 8'h00};
      1:       s = {"put", 8'h00};
      default: s = "tile";
    endcase
    return s[8*(3-int'(p)) +: 8];
  endfunction

  function automatic field_t to_field(input cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[FieldBits-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/bst_lex_step.sv
// next-state and token logic of the tokenizer for one source word
// depends on bst_pkg
`timescale 1ns / 1ps
`default_nettype none

module bst_lex_step import bst_pkg::*; (
  input  lex_state_t st_i,
  input  logic       is_end_i,
  input  logic [7:0] char_i,
  output lex_state_t nx_o,
  output step_t      step_o
);

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == ";" || c == "=" || c == "(" || c == ")" ||
           c == "{" || c == "}" || c == "," || c == ":";
  endfunction

  function automatic logic [KwCount-1:0] kw_miss(input cnt_t p, input logic [7:0] c);
    logic [KwCount-1:0] m;
    for (int k = 0; k < KwCount; k++) begin
      m[k] = (p >= cnt_t'(kw_len(k))) || (kw_char(k, p[1:0]) != c);
    end
    return m;
  endfunction

  function automatic tok_t mk_tok(input kind_e k, input cnt_t ln, input cnt_t cl,
                                  input cnt_t lg);
    tok_t t;
    t.kind   = k;
    t.line   = to_field(ln);
    t.column = to_field(cl);
    t.length = to_field(lg);
    t.last   = 1'b0;
    return t;
  endfunction

  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;

  lex_state_t nx;
  logic [1:0] n;
  tok_t       r0;
  tok_t       r1;
  tok_t       sym;
  logic       do_close;
  logic       do_disp;
  kind_e      run_kind;

  // kind of the open run if it closes now
  always_comb begin
    run_kind = KNumber;
    if (st_i.mode == ModeIdent) begin
      run_kind = KIdent;
      for (int k = 0; k < KwCount; k++) begin
        if (st_i.kw[k] && st_i.len == cnt_t'(kw_len(k))) run_kind = KKeyword;
      end
    end
  end

  always_comb begin
    nx       = st_i;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    sym      = '0;
    do_close = 1'b0;
    do_disp  = 1'b0;

    if (st_i.mode == ModeHalt) begin
      n = 2'd0;
    end else if (is_end_i) begin
      if (st_i.mode == ModeString) begin
        r0 = mk_tok(KError, st_i.line, st_i.start, st_i.len);
        n  = 2'd1;
      end else if (st_i.mode == ModeIdent || st_i.mode == ModeNumber) begin
        r0 = mk_tok(run_kind, st_i.line, st_i.start, st_i.len);
        r1 = mk_tok(KEnd, st_i.line, st_i.col, '0);
        n  = 2'd2;
      end else begin
        r0 = mk_tok(KEnd, st_i.line, st_i.col, '0);
        n  = 2'd1;
      end
      nx.mode = ModeHalt;
    end else begin
      unique case (st_i.mode)
        ModeIdent: begin
          if (is_alpha(char_i)) begin
            nx.kw  = st_i.kw & ~kw_miss(st_i.len, char_i);
            nx.len = sat_inc(st_i.len);
            nx.col = sat_inc(st_i.col);
          end else begin
            do_close = 1'b1;
            do_disp  = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(char_i)) begin
            nx.len = sat_inc(st_i.len);
            nx.col = sat_inc(st_i.col);
          end else begin
            do_close = 1'b1;
            do_disp  = 1'b1;
          end
        end
        ModeString: begin
          if (char_i == ChNl) begin
            r0      = mk_tok(KError, st_i.line, st_i.start, st_i.len);
            n       = 2'd1;
            nx.mode = ModeHalt;
          end else begin
            nx.len = sat_inc(st_i.len);
            nx.col = sat_inc(st_i.col);
            if (char_i == ChQuote) begin
              r0      = mk_tok(KString, st_i.line, st_i.start, nx.len);
              n       = 2'd1;
              nx.mode = ModeIdle;
            end
          end
        end
        ModeSlash: begin
          if (char_i == ChSlash) begin
            nx.mode = ModeComment;
          end else begin
            do_disp = 1'b1;
          end
        end
        ModeComment: begin
          if (char_i == ChNl) begin
            nx.line = sat_inc(st_i.line);
            nx.col  = '0;
            nx.mode = ModeIdle;
          end
        end
        default: begin
          do_disp = 1'b1;
        end
      endcase

      if (do_close) begin
        r0 = mk_tok(run_kind, st_i.line, st_i.start, st_i.len);
        n  = 2'd1;
      end

      if (do_disp) begin
        nx.mode = ModeIdle;
        if (char_i == ChNl) begin
          nx.line = sat_inc(st_i.line);
          nx.col  = '0;
        end else begin
          if (is_symbol(char_i)) begin
            sym = mk_tok(KSymbol, st_i.line, st_i.col, cnt_t'(1));
            if (do_close) begin
              r1 = sym;
              n  = 2'd2;
            end else begin
              r0 = sym;
              n  = 2'd1;
            end
          end else if (is_alpha(char_i)) begin
            nx.mode  = ModeIdent;
            nx.start = st_i.col;
            nx.len   = cnt_t'(1);
            nx.kw    = ~kw_miss('0, char_i);
          end else if (is_digit(char_i)) begin
            nx.mode  = ModeNumber;
            nx.start = st_i.col;
            nx.len   = cnt_t'(1);
            nx.kw    = '1;
          end else if (char_i == ChQuote) begin
            nx.mode  = ModeString;
            nx.start = st_i.col;
            nx.len   = cnt_t'(1);
            nx.kw    = '1;
          end else if (char_i == ChSlash) begin
            nx.mode = ModeSlash;
          end
          nx.col = sat_inc(st_i.col);
        end
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign nx_o      = nx;
  assign step_o.n  = n;
  assign step_o.r0 = r0;
  assign step_o.r1 = r1;

endmodule

`default_nettype wire

>>> hdl/byte_stream_tokenizer.sv
// path: an accepted source word is registered in the input stage, and its tokens in the result pair
// throughput: one source word per cycle while the output takes tokens; a word that
// gives two tokens stalls the input while the second token drains from the result pair
// reset: lexer idle, line and column zero, result pair empty; after an end or
// error token the lexer takes words and gives nothing until the next reset
// depends on bst_pkg and bst_lex_step
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer import bst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // token_line, token_column, token_length
  output logic [2:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic       in_valid_q, in_valid_d;
  logic       in_end_q, in_end_d;
  logic [7:0] in_char_q, in_char_d;

  lex_state_t lex_q, lex_d;
  lex_state_t lex_nx;
  step_t      step;

  logic [1:0] out_cnt_q, out_cnt_d;
  tok_t       rec0_q, rec0_d;
  tok_t       rec1_q, rec1_d;

  logic s_fire;
  logic m_fire;
  logic pair_free;
  logic advance;

  bst_lex_step u_step (
    .st_i     (lex_q),
    .is_end_i (in_end_q),
    .char_i   (in_char_q),
    .nx_o     (lex_nx),
    .step_o   (step)
  );

  assign m_fire    = (out_cnt_q != 2'd0) && m_axis_tready;
  assign pair_free = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && m_fire);
  assign advance   = in_valid_q && ((step.n == 2'd0) || pair_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_end_d   = in_end_q;
    in_char_d  = in_char_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
      in_end_d   = s_axis_tuser;
      in_char_d  = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  assign lex_d = advance ? lex_nx : lex_q;

  always_comb begin
    out_cnt_d = out_cnt_q;
    rec0_d    = rec0_q;
    rec1_d    = rec1_q;
    if (advance && step.n != 2'd0) begin
      out_cnt_d = step.n;
      rec0_d    = step.r0;
      rec1_d    = step.r1;
    end else if (m_fire) begin
      if (out_cnt_q == 2'd2) begin
        out_cnt_d = 2'd1;
        rec0_d    = rec1_q;
      end else begin
        out_cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_cnt_q   <= 2'd0;
      lex_q.mode  <= ModeIdle;
      lex_q.line  <= '0;
      lex_q.col   <= '0;
      lex_q.start <= '0;
      lex_q.len   <= '0;
      lex_q.kw    <= '1;
    end else begin
      in_valid_q <= in_valid_d;
      out_cnt_q  <= out_cnt_d;
      lex_q      <= lex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_end_q  <= in_end_d;
    in_char_q <= in_char_d;
    rec0_q    <= rec0_d;
    rec1_q    <= rec1_d;
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = {rec0_q.length, rec0_q.column, rec0_q.line};
  assign m_axis_tuser  = rec0_q.kind;
  assign m_axis_tlast  = rec0_q.last;

  // result pair never overfills
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3)
    else $error("result pair count out of range");

  // the first of two pending tokens is never marked last
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q == 2'd2 |-> !rec0_q.last)
    else $error("first of a token pair marked last");

  // an end or error token only leaves once the lexer has halted
  a_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && (m_axis_tuser == KEnd || m_axis_tuser == KError)) |-> lex_q.mode == ModeHalt)
    else $error("end or error token without halt");

  // halt holds until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lex_q.mode == ModeHalt |=> lex_q.mode == ModeHalt)
    else $error("lexer left halt");

  // a halted lexer loads no tokens
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lex_q.mode == ModeHalt && advance) |-> step.n == 2'd0)
    else $error("token produced while halted");

endmodule

`default_nettype wire
